// ----- rtl/rubc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rubc_pkg;

  localparam int HOUR_BINS = 24;
  localparam int DAY_BINS  = 31;
  localparam int BIN_WIDTH = 16;

  localparam int SWEEP_LEN = (HOUR_BINS > DAY_BINS) ? HOUR_BINS : DAY_BINS;
  localparam int IDX_W     = $clog2(SWEEP_LEN);
  localparam int HIDX_W    = $clog2(HOUR_BINS);
  localparam int DIDX_W    = $clog2(DAY_BINS);
  localparam int CMP_W     = ((IDX_W > 5) ? IDX_W : 5) + 1;
  localparam int ACC_W     = (BIN_WIDTH + 7 > 22) ? BIN_WIDTH + 7 : 22;
  localparam int SUM_W     = 21;
  localparam int REPORT_W  = 16;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic [2:0] REQ_PULSE  = 3'd0;
  localparam logic [2:0] REQ_CLEAR  = 3'd1;
  localparam logic [2:0] REQ_LOAD   = 3'd2;
  localparam logic [2:0] REQ_SET    = 3'd3;
  localparam logic [2:0] REQ_UPDATE = 3'd4;

  typedef logic [BIN_WIDTH-1:0] bin_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] load_value;
    logic [4:0]  clock_hour;
    logic [4:0]  clock_day;
    logic [3:0]  clock_month;
    logic [4:0]  hour_select;
    logic [4:0]  day_select;
  } in_t;

  typedef struct packed {
    logic [31:0]      total_count;
    logic [15:0]      hour_count;
    logic [15:0]      day_count;
    logic [SUM_W-1:0] window_sum;
    logic             commit_pulse;
    logic             dirty_now;
  } out_t;

  typedef struct packed {
    logic pulse;
    logic clear;
    logic age_hour;
    logic age_day;
  } bin_op_t;

  typedef struct packed {
    logic [REPORT_W-1:0] hour_count;
    logic [REPORT_W-1:0] day_count;
    logic [SUM_W-1:0]    window_sum;
  } sweep_res_t;

  function automatic logic [REPORT_W-1:0] bin_report(input bin_t b);
    logic [BIN_WIDTH+REPORT_W-1:0] ext;
    ext = (BIN_WIDTH + REPORT_W)'(b);
    return ext[REPORT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rubc_bins.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rubc_bins (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rubc_pkg::bin_op_t op,
  input  wire rubc_pkg::idx_t   rd_idx,
  output rubc_pkg::bin_t        rd_hour,
  output rubc_pkg::bin_t        rd_day
);
  import rubc_pkg::*;

  bin_t hour_r [HOUR_BINS];
  bin_t day_r  [DAY_BINS];

  always_ff @(posedge clk) begin
    if (!rst_n || op.clear) begin
      for (int i = 0; i < HOUR_BINS; i++) begin
        hour_r[i] <= '0;
      end
      for (int i = 0; i < DAY_BINS; i++) begin
        day_r[i] <= '0;
      end
    end else begin
      if (op.pulse) begin
        hour_r[0] <= hour_r[0] + bin_t'(1);
        day_r[0]  <= day_r[0] + bin_t'(1);
      end
      if (op.age_hour) begin
        for (int i = 1; i < HOUR_BINS; i++) begin
          hour_r[i] <= hour_r[i-1];
        end
        hour_r[0] <= '0;
      end
      if (op.age_day) begin
        for (int i = 1; i < DAY_BINS; i++) begin
          day_r[i] <= day_r[i-1];
        end
        day_r[0] <= '0;
      end
    end
  end

  always_comb begin
    rd_hour = '0;
    rd_day  = '0;
    if (CMP_W'(rd_idx) < CMP_W'(HOUR_BINS)) begin
      rd_hour = hour_r[rd_idx[HIDX_W-1:0]];
    end
    if (CMP_W'(rd_idx) < CMP_W'(DAY_BINS)) begin
      rd_day = day_r[rd_idx[DIDX_W-1:0]];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rubc_sweep.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rubc_sweep (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [4:0]         hour_select,
  input  wire logic [4:0]         day_select,
  input  wire rubc_pkg::bin_t     rd_hour,
  input  wire rubc_pkg::bin_t     rd_day,
  output rubc_pkg::idx_t          rd_idx,
  output logic                    done,
  output rubc_pkg::sweep_res_t    res
);
  import rubc_pkg::*;

  logic             busy_r;
  logic             done_r;
  idx_t             idx_r;
  logic [4:0]       hsel_r;
  logic [4:0]       dsel_r;
  logic [ACC_W-1:0] acc_r;
  bin_t             hour_cap_r;
  bin_t             day_cap_r;
  logic             last_idx;
  logic             in_hour;
  logic             in_day;

  assign last_idx = (CMP_W'(idx_r) == CMP_W'(SWEEP_LEN - 1));
  assign in_hour  = (CMP_W'(idx_r) < CMP_W'(HOUR_BINS));
  assign in_day   = (CMP_W'(idx_r) < CMP_W'(DAY_BINS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last_idx) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx_r      <= '0;
      acc_r      <= '0;
      hour_cap_r <= '0;
      day_cap_r  <= '0;
      hsel_r     <= hour_select;
      dsel_r     <= day_select;
    end else if (busy_r) begin
      idx_r <= idx_r + idx_t'(1);
      if (in_day) begin
        acc_r <= acc_r + ACC_W'(rd_day);
        if (CMP_W'(idx_r) == CMP_W'(dsel_r)) begin
          day_cap_r <= rd_day;
        end
      end
      if (in_hour && (CMP_W'(idx_r) == CMP_W'(hsel_r))) begin
        hour_cap_r <= rd_hour;
      end
    end
  end

  assign rd_idx         = idx_r;
  assign done           = done_r;
  assign res.hour_count = bin_report(hour_cap_r);
  assign res.day_count  = bin_report(day_cap_r);
  assign res.window_sum = (acc_r > ACC_W'(SUM_MAX)) ? SUM_MAX : acc_r[SUM_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/rolling_usage_history_counter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Transactions are accepted only in the idle state; the input stalls until
// the sweep has loaded its result into the output register. The sweep reads
// one index per cycle; one adder sums the daily bins, selectors pick bins.
// The output register lets the next transaction in while a result waits.
// Reset is synchronous and active low; it clears the total, all bins, the
// stored time, the dirty mark and all handshake state.
module rolling_usage_history_counter (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire rubc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rubc_pkg::out_t      out_data
);
  import rubc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;

  logic [1:0]  state_r;
  logic [1:0]  state_nxt;
  logic [31:0] total_r;
  logic [4:0]  last_hour_r;
  logic [4:0]  last_day_r;
  logic [3:0]  last_month_r;
  logic        dirty_r;
  logic        commit_r;
  logic        out_valid_r;
  out_t        out_data_r;

  logic        accept;
  logic        sweep_done;
  logic        out_free;
  logic        load_out;
  bin_op_t     op;
  idx_t        rd_idx;
  bin_t        rd_hour;
  bin_t        rd_day;
  sweep_res_t  res;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = out_free && ((state_r == S_DONE) || ((state_r == S_SWEEP) && sweep_done));

  always_comb begin
    op = '0;
    if (accept) begin
      case (in_data.req_type)
        REQ_PULSE: op.pulse = 1'b1;
        REQ_CLEAR, REQ_LOAD: op.clear = 1'b1;
        REQ_UPDATE: begin
          op.age_hour = (in_data.clock_hour != last_hour_r);
          op.age_day  = (in_data.clock_day != last_day_r);
        end
        default: op = '0;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (sweep_done) begin
          state_nxt = out_free ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      last_hour_r  <= '0;
      last_day_r   <= '0;
      last_month_r <= '0;
      dirty_r      <= 1'b0;
      commit_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        commit_r <= (in_data.req_type == REQ_UPDATE) && dirty_r;
        case (in_data.req_type)
          REQ_PULSE: begin
            total_r <= total_r + 32'd1;
            dirty_r <= 1'b1;
          end
          REQ_CLEAR: begin
            total_r <= '0;
            dirty_r <= 1'b1;
          end
          REQ_LOAD: begin
            total_r <= in_data.load_value;
            dirty_r <= 1'b1;
          end
          REQ_SET: begin
            last_hour_r  <= in_data.clock_hour;
            last_day_r   <= in_data.clock_day;
            last_month_r <= in_data.clock_month;
          end
          REQ_UPDATE: begin
            last_hour_r  <= in_data.clock_hour;
            last_day_r   <= in_data.clock_day;
            last_month_r <= in_data.clock_month;
            dirty_r      <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.total_count  <= total_r;
      out_data_r.hour_count   <= res.hour_count;
      out_data_r.day_count    <= res.day_count;
      out_data_r.window_sum   <= res.window_sum;
      out_data_r.commit_pulse <= commit_r;
      out_data_r.dirty_now    <= dirty_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rubc_bins u_bins (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (op),
    .rd_idx  (rd_idx),
    .rd_hour (rd_hour),
    .rd_day  (rd_day)
  );

  rubc_sweep u_sweep (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (accept),
    .hour_select (in_data.hour_select),
    .day_select  (in_data.day_select),
    .rd_hour     (rd_hour),
    .rd_day      (rd_day),
    .rd_idx      (rd_idx),
    .done        (sweep_done),
    .res         (res)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rubc_pkg::*;

  localparam logic [2:0] REQ_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] REQ_RESERVED_LAST  = 3'd7;
  localparam int         CYCLE_LIMIT        = 1000000;
  localparam int         DRAIN_CYCLES       = 50;
  localparam int         HOLD_OFF_CYCLES    = 400;

  typedef enum logic [1:0] {STALL_NEVER, STALL_RANDOM, STALL_PERIODIC} stall_style_t;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic [31:0] meter_total;
  bin_t        meter_hours[HOUR_BINS];
  bin_t        meter_days[DAY_BINS];
  logic [4:0]  meter_hour;
  logic [4:0]  meter_day;
  logic [3:0]  meter_month;
  logic        meter_dirty;

  out_t pending_reports[$];

  int unsigned  cycle_count     = 0;
  int           error_count     = 0;
  int           reports_checked = 0;
  int           commits_seen    = 0;
  int           pulses_sent     = 0;
  int           updates_sent    = 0;
  int           requests_sent   = 0;
  int           blocked_cycles  = 0;
  int           burst_left      = 0;
  bit           pacing_on       = 1'b1;
  int           hold_request    = 0;
  int           hold_left       = 0;
  int           style_left      = 0;
  stall_style_t stall_style     = STALL_NEVER;
  int           wall_hour       = 0;
  int           wall_day        = 1;
  int           wall_month      = 1;

  rolling_usage_history_counter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic out_t predict_meter_report(input in_t rq);
    out_t             rep;
    longint unsigned  acc;
    rep = '0;
    case (rq.req_type)
      REQ_PULSE: begin
        meter_total   = meter_total + 32'd1;
        meter_hours[0] = meter_hours[0] + bin_t'(1);
        meter_days[0]  = meter_days[0] + bin_t'(1);
        meter_dirty   = 1'b1;
      end
      REQ_CLEAR, REQ_LOAD: begin
        for (int i = 0; i < HOUR_BINS; i++) meter_hours[i] = '0;
        for (int i = 0; i < DAY_BINS; i++) meter_days[i] = '0;
        meter_total = (rq.req_type == REQ_LOAD) ? rq.load_value : 32'd0;
        meter_dirty = 1'b1;
      end
      REQ_SET: begin
        meter_hour  = rq.clock_hour;
        meter_day   = rq.clock_day;
        meter_month = rq.clock_month;
      end
      REQ_UPDATE: begin
        if (meter_hour != rq.clock_hour) begin
          meter_hour = rq.clock_hour;
          for (int i = HOUR_BINS - 1; i > 0; i--) meter_hours[i] = meter_hours[i-1];
          meter_hours[0] = '0;
        end
        if (meter_day != rq.clock_day) begin
          meter_day = rq.clock_day;
          for (int i = DAY_BINS - 1; i > 0; i--) meter_days[i] = meter_days[i-1];
          meter_days[0] = '0;
        end
        meter_month = rq.clock_month;
        if (meter_dirty) begin
          meter_dirty      = 1'b0;
          rep.commit_pulse = 1'b1;
        end
      end
      default: begin
      end
    endcase
    acc = 0;
    for (int i = 0; i < DAY_BINS; i++) acc += meter_days[i];
    if (acc > SUM_MAX) acc = SUM_MAX;
    rep.total_count = meter_total;
    if (rq.hour_select < HOUR_BINS) rep.hour_count = 16'(meter_hours[rq.hour_select]);
    if (rq.day_select < DAY_BINS) rep.day_count = 16'(meter_days[rq.day_select]);
    rep.window_sum = acc[SUM_W-1:0];
    rep.dirty_now  = meter_dirty;
    return rep;
  endfunction

  function automatic in_t build_request(input logic [2:0] kind, input int hr, input int dy,
                                        input int mo, input int hsel, input int dsel,
                                        input logic [31:0] load);
    in_t rq;
    rq.req_type    = kind;
    rq.load_value  = load;
    rq.clock_hour  = 5'(hr);
    rq.clock_day   = 5'(dy);
    rq.clock_month = 4'(mo);
    rq.hour_select = 5'(hsel);
    rq.day_select  = 5'(dsel);
    return rq;
  endfunction

  task automatic send_request(input in_t rq);
    int gap;
    in_valid <= 1'b1;
    in_data  <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_reports.push_back(predict_meter_report(rq));
    requests_sent++;
    if (rq.req_type == REQ_PULSE) pulses_sent++;
    if (rq.req_type == REQ_UPDATE) updates_sent++;
    if (pacing_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 12);
        gap        = $urandom_range(1, 40);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: a long hold-off when asked for, otherwise one of three stall
  // styles (none, random, periodic), picked anew at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_request > 0) begin
      hold_left    = hold_request - 1;
      hold_request = 0;
      out_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        style_left  = $urandom_range(100, 500);
        stall_style = stall_style_t'($urandom_range(0, 2));
      end else begin
        style_left--;
      end
      case (stall_style)
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 1) == 1);
        STALL_PERIODIC: out_stall <= ((cycle_count % 7) < 3);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("Result transaction arrived with no request outstanding");
        error_count++;
      end else begin
        out_t want;
        want = pending_reports.pop_front();
        reports_checked++;
        if (out_data.commit_pulse) commits_seen++;
        if (out_data.total_count !== want.total_count) begin
          $error("total_count: expected %0d, got %0d", want.total_count, out_data.total_count);
          error_count++;
        end
        if (out_data.hour_count !== want.hour_count) begin
          $error("hour_count: expected %0d, got %0d", want.hour_count, out_data.hour_count);
          error_count++;
        end
        if (out_data.day_count !== want.day_count) begin
          $error("day_count: expected %0d, got %0d", want.day_count, out_data.day_count);
          error_count++;
        end
        if (out_data.window_sum !== want.window_sum) begin
          $error("window_sum: expected %0d, got %0d", want.window_sum, out_data.window_sum);
          error_count++;
        end
        if (out_data.commit_pulse !== want.commit_pulse) begin
          $error("commit_pulse: expected %0d, got %0d", want.commit_pulse,
                 out_data.commit_pulse);
          error_count++;
        end
        if (out_data.dirty_now !== want.dirty_now) begin
          $error("dirty_now: expected %0d, got %0d", want.dirty_now, out_data.dirty_now);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && in_stall) blocked_cycles++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("Run timed out with %0d results outstanding", pending_reports.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed_cases();
    send_request(build_request(REQ_PULSE, 0, 0, 0, 0, 0, 32'd0));
    send_request(build_request(REQ_PULSE, 0, 0, 0, HOUR_BINS - 1, DAY_BINS - 1, 32'd0));
    send_request(build_request(REQ_UPDATE, 0, 0, 0, 0, 0, 32'd0));
    send_request(build_request(REQ_UPDATE, 1, 0, 0, 1, 0, 32'd0));
    send_request(build_request(REQ_SET, 23, 31, 12, 0, 0, 32'd0));
    send_request(build_request(REQ_PULSE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_request(build_request(REQ_PULSE, 0, 0, 0, 2, 0, 32'd0));
    send_request(build_request(REQ_UPDATE, 0, 1, 1, 1, 1, 32'd0));
    send_request(build_request(REQ_LOAD, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_request(build_request(REQ_PULSE, 0, 0, 0, 0, 0, 32'd0));
    send_request(build_request(REQ_PULSE, 0, 0, 0, 0, 0, 32'd0));
    send_request(build_request(REQ_LOAD, 0, 0, 0, 0, 0, 32'd0));
    send_request(build_request(REQ_PULSE, 0, 0, 0, 0, 0, 32'd0));
    send_request(build_request(REQ_CLEAR, 0, 0, 0, 0, 0, 32'd0));
    send_request(build_request(REQ_RESERVED_FIRST, 5, 5, 5, HOUR_BINS, DAY_BINS, 32'd7));
    send_request(build_request(REQ_RESERVED_FIRST + 3'd1, 0, 0, 0, 31, 31, 32'd0));
    send_request(build_request(REQ_RESERVED_LAST, 31, 31, 15, 0, 0, 32'hFFFF_FFFF));
    send_request(build_request(REQ_SET, 31, 0, 15, 0, 0, 32'd0));
    send_request(build_request(REQ_PULSE, 0, 0, 0, 31, 31, 32'd0));
    send_request(build_request(REQ_UPDATE, 31, 0, 15, 0, 0, 32'd0));
    send_request(build_request(REQ_UPDATE, 30, 31, 0, 1, 1, 32'd0));
    send_request(build_request(REQ_PULSE, 0, 0, 0, HOUR_BINS, DAY_BINS - 1, 32'd0));
  endtask

  // Mostly pulses and clock updates that follow a plausible wall clock, with
  // clears, loads, out-of-range clock values and reserved kinds mixed in.
  task automatic test_random_traffic(input int count);
    in_t rq;
    int  pick;
    int  step;
    send_request(build_request(REQ_SET, wall_hour, wall_day, wall_month, 0, 0, $urandom));
    for (int n = 0; n < count; n++) begin
      if (n % 200 == 0) pacing_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick >= 55 && pick < 77) begin
        step = $urandom_range(0, 9);
        if (step >= 2 && step <= 7) wall_hour++;
        else if (step == 8) wall_day++;
        else if (step == 9) wall_hour = $urandom_range(0, 23);
      end else if (pick >= 77 && pick < 81) begin
        wall_hour  = $urandom_range(0, 23);
        wall_day   = $urandom_range(1, 31);
        wall_month = $urandom_range(1, 12);
      end
      if (wall_hour > 23) begin
        wall_hour = 0;
        wall_day++;
      end
      if (wall_day > 31) begin
        wall_day = 1;
        wall_month++;
      end
      if (wall_month > 12) wall_month = 1;
      rq = build_request(REQ_PULSE, wall_hour, wall_day, wall_month,
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(0, HOUR_BINS - 1),
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(0, DAY_BINS - 1),
                         $urandom);
      if (pick < 55) begin
        rq.req_type = REQ_PULSE;
      end else if (pick < 77) begin
        rq.req_type = REQ_UPDATE;
      end else if (pick < 81) begin
        rq.req_type = REQ_SET;
      end else if (pick < 85) begin
        rq.req_type = REQ_CLEAR;
      end else if (pick < 89) begin
        rq.req_type = REQ_LOAD;
      end else if (pick < 95) begin
        rq.req_type    = ($urandom_range(0, 1) == 1) ? REQ_UPDATE : REQ_SET;
        rq.clock_hour  = 5'($urandom_range(0, 31));
        rq.clock_day   = 5'($urandom_range(0, 31));
        rq.clock_month = 4'($urandom_range(0, 15));
      end else begin
        rq.req_type = 3'($urandom_range(REQ_RESERVED_FIRST, REQ_RESERVED_LAST));
      end
      send_request(rq);
    end
    pacing_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the block fills up and pushes back on its input.
  task automatic test_output_hold_off();
    pacing_on    = 1'b0;
    hold_request = HOLD_OFF_CYCLES;
    for (int n = 0; n < 16; n++)
      send_request(build_request(($urandom_range(0, 3) == 0) ? REQ_UPDATE : REQ_PULSE,
                                 $urandom_range(0, 23), $urandom_range(1, 31),
                                 $urandom_range(1, 12), $urandom_range(0, HOUR_BINS - 1),
                                 $urandom_range(0, DAY_BINS - 1), $urandom));
    pacing_on = 1'b1;
  endtask

  initial begin
    meter_total = '0;
    meter_hour  = '0;
    meter_day   = '0;
    meter_month = '0;
    meter_dirty = 1'b0;
    for (int i = 0; i < HOUR_BINS; i++) meter_hours[i] = '0;
    for (int i = 0; i < DAY_BINS; i++) meter_days[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_traffic(1540);
    test_output_hold_off();
    test_random_traffic(40);

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d pulses, %0d clock updates); %0d commits reported.",
             requests_sent, pulses_sent, updates_sent, commits_seen);
    $display("Checked %0d results; input was held back for %0d cycles in total.",
             reports_checked, blocked_cycles);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
